// ----- hdl/psl_pkg.sv -----
// shared types, constants and helpers for the packet sequence loss tracker
// no dependencies; imported by the tracker and its checker
`default_nettype none
package psl_pkg;

	localparam int SEQ_W = 16;
	localparam int CNT_W = 32;

	localparam logic [1:0] KIND_DATA      = 2'd0;
	localparam logic [1:0] KIND_PARITY    = 2'd1;
	localparam logic [1:0] KIND_RECOVERED = 2'd2;
	localparam logic [1:0] KIND_CLEAR     = 2'd3;

	// saturating add of two counter-wide values
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- hdl/packet_sequence_loss_tracker.sv -----
// packet sequence loss tracker: missing-number ring in one synchronous memory
// plus statistics counters; depends on psl_pkg
// result word: an accepted word passes S_EVAL and then S_DONE, where its result is
//   registered; parity, recovered, clear and in-order data words go straight
//   there, a jump ahead by g first writes min(g-1, RING_DEPTH) ring entries, a late
//   data word first reads up to RING_DEPTH ring entries (single memory read port)
// throughput: one word in flight; next word taken once the result is latched
// reset: async active low; then a sweep over every ring address clears the ring
//   while pkt_stall stays high
`default_nettype none
module packet_sequence_loss_tracker
	import psl_pkg::*;
#(
	parameter int RING_DEPTH  = 128,
	parameter int WRAP_WINDOW = 255
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pkt_valid,
	output logic                  pkt_stall,
	input  wire logic [1:0]       kind,
	input  wire logic [SEQ_W-1:0] seq_number,
	input  wire logic [SEQ_W-1:0] packet_size,
	output logic                  stat_valid,
	input  wire logic             stat_stall,
	output logic [CNT_W-1:0]      lost_count,
	output logic [CNT_W-1:0]      duplicate_count,
	output logic [CNT_W-1:0]      disorder_count,
	output logic [CNT_W-1:0]      recovered_count,
	output logic [CNT_W-1:0]      data_packets,
	output logic [CNT_W-1:0]      data_bytes,
	output logic [CNT_W-1:0]      parity_packets,
	output logic [CNT_W-1:0]      parity_bytes,
	output logic [SEQ_W-1:0]      highest_seq,
	output logic                  seq_started
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam logic [AW-1:0]    LAST_ADDR   = AW'(RING_DEPTH - 1);
	localparam logic [SEQ_W-1:0] WIN         = SEQ_W'(WRAP_WINDOW);
	localparam logic [SEQ_W:0]   AHEAD_LIMIT = (SEQ_W + 1)'(65536 - WRAP_WINDOW);
	localparam logic [SEQ_W:0]   DEPTH_X     = (SEQ_W + 1)'(RING_DEPTH);
	localparam logic [SEQ_W-1:0] DEPTH_S     = SEQ_W'(RING_DEPTH);

	typedef enum logic [5:0] {
		S_INIT   = 6'b000001,
		S_IDLE   = 6'b000010,
		S_EVAL   = 6'b000100,
		S_INSERT = 6'b001000,
		S_SEARCH = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q;

	logic [1:0]       kind_q;
	logic [SEQ_W-1:0] seq_q, size_q, top_q;
	logic             started_q;
	logic [CNT_W-1:0] lost_q, dup_q, disorder_q, rec_q;
	logic [CNT_W-1:0] dpkt_q, dbytes_q, ppkt_q, pbytes_q;
	logic [AW-1:0]    wptr_q, addr_q;
	logic [SEQ_W-1:0] ins_seq_q;
	logic [CW-1:0]    ins_left_q;
	logic             issue_q;
	logic             rd_pend_s1;
	logic [AW-1:0]    rd_addr_s1;
	logic [SEQ_W:0]   rd_data_s1;
	logic             stat_valid_q;

	// ring entry: valid bit on top of the missing sequence number
	logic [SEQ_W:0] ring_mem [RING_DEPTH];

	// sequence distance against the highest number seen
	logic [SEQ_W-1:0] diff, gap, first_off, ins_start;
	logic             seq_ge, ahead, gap_big;
	logic [CW-1:0]    ins_n;

	always_comb begin
		diff      = seq_q - top_q;
		seq_ge    = seq_q >= top_q;
		ahead     = seq_ge ? ((diff != '0) && (diff <= WIN))
		                   : ({1'b0, diff} < AHEAD_LIMIT);
		gap       = diff - SEQ_W'(1);
		gap_big   = {1'b0, gap} > DEPTH_X;
		first_off = gap_big ? (gap - DEPTH_S + SEQ_W'(1)) : SEQ_W'(1);
		ins_start = top_q + first_off;
		ins_n     = gap_big ? CW'(RING_DEPTH) : CW'(gap);
	end

	logic hit, scan_end;
	assign hit      = rd_pend_s1 && rd_data_s1[SEQ_W] && (rd_data_s1[SEQ_W-1:0] == seq_q);
	assign scan_end = rd_pend_s1 && (rd_addr_s1 == LAST_ADDR);

	// memory write port
	logic           mem_we;
	logic [AW-1:0]  mem_wa;
	logic [SEQ_W:0] mem_wd;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = '0;
		unique case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
			end
			S_INSERT: begin
				mem_we = 1'b1;
				mem_wa = wptr_q;
				mem_wd = {1'b1, ins_seq_q};
			end
			S_SEARCH: begin
				mem_we = hit;
				mem_wa = rd_addr_s1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			ring_mem[mem_wa] <= mem_wd;
		rd_data_s1 <= ring_mem[addr_q];
	end

	logic out_load;
	assign out_load = (state_q == S_DONE) && (!stat_valid_q || !stat_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			top_q        <= '0;
			started_q    <= 1'b0;
			lost_q       <= '0;
			dup_q        <= '0;
			disorder_q   <= '0;
			rec_q        <= '0;
			dpkt_q       <= '0;
			dbytes_q     <= '0;
			ppkt_q       <= '0;
			pbytes_q     <= '0;
			wptr_q       <= '0;
			addr_q       <= '0;
			ins_left_q   <= '0;
			issue_q      <= 1'b0;
			rd_pend_s1   <= 1'b0;
			stat_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= 1'b0;
			if (out_load)
				stat_valid_q <= 1'b1;
			else if (!stat_stall)
				stat_valid_q <= 1'b0;

			unique case (state_q)
				S_INIT: begin
					// clearing sweep over the ring
					addr_q <= addr_q + AW'(1);
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pkt_valid)
						state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= S_DONE;
					case (kind_q)
						KIND_DATA: begin
							dpkt_q   <= sat_add(dpkt_q, CNT_W'(1));
							dbytes_q <= sat_add(dbytes_q, CNT_W'(size_q));
							if (!started_q) begin
								top_q     <= seq_q;
								started_q <= 1'b1;
							end else if (ahead) begin
								lost_q    <= sat_add(lost_q, CNT_W'(gap));
								top_q     <= seq_q;
								ins_seq_q <= ins_start;
								ins_left_q <= ins_n;
								if (gap != '0)
									state_q <= S_INSERT;
							end else begin
								disorder_q <= sat_add(disorder_q, CNT_W'(1));
								addr_q     <= '0;
								issue_q    <= 1'b1;
								state_q    <= S_SEARCH;
							end
						end
						KIND_PARITY: begin
							ppkt_q   <= sat_add(ppkt_q, CNT_W'(1));
							pbytes_q <= sat_add(pbytes_q, CNT_W'(size_q));
						end
						KIND_RECOVERED: begin
							rec_q <= sat_add(rec_q, CNT_W'(1));
						end
						default: begin
							dup_q      <= '0;
							disorder_q <= '0;
							rec_q      <= '0;
							dpkt_q     <= '0;
							dbytes_q   <= '0;
							ppkt_q     <= '0;
							pbytes_q   <= '0;
						end
					endcase
				end
				S_INSERT: begin
					wptr_q     <= (wptr_q == LAST_ADDR) ? '0 : wptr_q + AW'(1);
					ins_seq_q  <= ins_seq_q + SEQ_W'(1);
					ins_left_q <= ins_left_q - CW'(1);
					if (ins_left_q == CW'(1))
						state_q <= S_DONE;
				end
				S_SEARCH: begin
					// reads issued one per cycle, each compared in the cycle after its issue
					if (issue_q) begin
						addr_q <= addr_q + AW'(1);
						if (addr_q == LAST_ADDR) begin
							addr_q  <= '0;
							issue_q <= 1'b0;
						end
					end
					rd_pend_s1 <= issue_q;
					if (hit) begin
						if (lost_q != '0)
							lost_q <= lost_q - CNT_W'(1);
						issue_q    <= 1'b0;
						addr_q     <= '0;
						rd_pend_s1 <= 1'b0;
						state_q    <= S_DONE;
					end else if (scan_end) begin
						dup_q      <= sat_add(dup_q, CNT_W'(1));
						rd_pend_s1 <= 1'b0;
						state_q    <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	// item capture and read address pipeline
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pkt_valid) begin
			kind_q <= kind;
			seq_q  <= seq_number;
			size_q <= packet_size;
		end
		rd_addr_s1 <= addr_q;
	end

	// result word register
	always_ff @(posedge clk) begin
		if (out_load) begin
			lost_count      <= lost_q;
			duplicate_count <= dup_q;
			disorder_count  <= disorder_q;
			recovered_count <= rec_q;
			data_packets    <= dpkt_q;
			data_bytes      <= dbytes_q;
			parity_packets  <= ppkt_q;
			parity_bytes    <= pbytes_q;
			highest_seq     <= top_q;
			seq_started     <= started_q;
		end
	end

	assign pkt_stall  = (state_q != S_IDLE);
	assign stat_valid = stat_valid_q;

endmodule
`default_nettype wire

// ----- hdl/psl_check.sv -----
// port-level checker for the packet sequence loss tracker, bound to its top
// depends on psl_pkg for field widths
`default_nettype none
module psl_check
	import psl_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             pkt_valid,
	input wire logic             pkt_stall,
	input wire logic [1:0]       kind,
	input wire logic [SEQ_W-1:0] seq_number,
	input wire logic [SEQ_W-1:0] packet_size,
	input wire logic             stat_valid,
	input wire logic             stat_stall,
	input wire logic [CNT_W-1:0] lost_count,
	input wire logic [CNT_W-1:0] duplicate_count,
	input wire logic [CNT_W-1:0] disorder_count,
	input wire logic [CNT_W-1:0] recovered_count,
	input wire logic [CNT_W-1:0] data_packets,
	input wire logic [CNT_W-1:0] data_bytes,
	input wire logic [CNT_W-1:0] parity_packets,
	input wire logic [CNT_W-1:0] parity_bytes,
	input wire logic [SEQ_W-1:0] highest_seq,
	input wire logic             seq_started
);

	// one word in flight: an accepted word closes the input side
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && !pkt_stall |=> pkt_stall)
		else $error("input taken again right after an accept");

	// input side stays closed while reset is applied
	a_stall_in_reset: assert property (@(posedge clk)
		!arst_n |-> (pkt_stall !== 1'b0))
		else $error("input open during reset");

	// a stalled input word is held by the sender
	a_input_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && pkt_stall |=> pkt_valid && $stable(kind) && $stable(seq_number)
			&& $stable(packet_size))
		else $error("stalled input word changed");

	// an accepted result word that reports started is not directly followed by one that does not
	a_started_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stat_valid && !stat_stall && seq_started |=> !stat_valid || seq_started)
		else $error("seq_started fell");

	// a held result word keeps its counters
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stat_valid && stat_stall |=> stat_valid && $stable(lost_count)
			&& $stable(duplicate_count) && $stable(disorder_count)
			&& $stable(recovered_count) && $stable(data_packets)
			&& $stable(data_bytes) && $stable(parity_packets)
			&& $stable(parity_bytes) && $stable(highest_seq)
			&& $stable(seq_started))
		else $error("stalled result word changed");

endmodule

bind packet_sequence_loss_tracker psl_check u_psl_check (.*);
`default_nettype wire

// ----- test/packet_sequence_loss_tracker_tb.sv -----
// testbench for packet_sequence_loss_tracker: directed and random packet streams with
// random idling on both sides, checked word by word against a built-in tracker model
// depends on psl_pkg and the tracker rtl
`default_nettype none
module packet_sequence_loss_tracker_tb;
	import psl_pkg::*;

	localparam int TRACK_DEPTH     = 128;
	localparam int WINDOW          = 255;
	localparam int SEQ_SPAN        = 65536;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int LATE_POOL_MAX   = 64;
	localparam int PRINT_MAX       = 40;

	typedef struct packed {
		logic [CNT_W-1:0] lost_count;
		logic [CNT_W-1:0] duplicate_count;
		logic [CNT_W-1:0] disorder_count;
		logic [CNT_W-1:0] recovered_count;
		logic [CNT_W-1:0] data_packets;
		logic [CNT_W-1:0] data_bytes;
		logic [CNT_W-1:0] parity_packets;
		logic [CNT_W-1:0] parity_bytes;
		logic [SEQ_W-1:0] highest_seq;
		logic             seq_started;
	} stat_word_t;

	logic             clk;
	logic             arst_n;
	logic             pkt_valid;
	logic             pkt_stall;
	logic [1:0]       kind;
	logic [SEQ_W-1:0] seq_number;
	logic [SEQ_W-1:0] packet_size;
	logic             stat_valid;
	logic             stat_stall;
	logic [CNT_W-1:0] lost_count;
	logic [CNT_W-1:0] duplicate_count;
	logic [CNT_W-1:0] disorder_count;
	logic [CNT_W-1:0] recovered_count;
	logic [CNT_W-1:0] data_packets;
	logic [CNT_W-1:0] data_bytes;
	logic [CNT_W-1:0] parity_packets;
	logic [CNT_W-1:0] parity_bytes;
	logic [SEQ_W-1:0] highest_seq;
	logic             seq_started;

	// tracker model state
	stat_word_t       model_stats = '0;
	logic [SEQ_W-1:0] gap_ring [TRACK_DEPTH];
	bit               gap_ring_ok [TRACK_DEPTH];
	int               gap_ring_wr = 0;

	stat_word_t       expected_stats [$];
	logic [SEQ_W-1:0] late_pool [$];
	int               mismatch_total = 0;
	int               idle_cycles = 0;
	bit               sender_gaps = 1'b0;
	bit               receiver_stalls = 1'b0;
	int               hold_request = 0;
	int               hold_left = 0;
	int               stall_run = 0;

	packet_sequence_loss_tracker #(
		.RING_DEPTH(TRACK_DEPTH),
		.WRAP_WINDOW(WINDOW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.kind(kind),
		.seq_number(seq_number),
		.packet_size(packet_size),
		.stat_valid(stat_valid),
		.stat_stall(stat_stall),
		.lost_count(lost_count),
		.duplicate_count(duplicate_count),
		.disorder_count(disorder_count),
		.recovered_count(recovered_count),
		.data_packets(data_packets),
		.data_bytes(data_bytes),
		.parity_packets(parity_packets),
		.parity_bytes(parity_bytes),
		.highest_seq(highest_seq),
		.seq_started(seq_started)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [CNT_W-1:0] counter_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
		logic [CNT_W:0] total;
		total = {1'b0, a} + {1'b0, b};
		return total[CNT_W] ? {CNT_W{1'b1}} : total[CNT_W-1:0];
	endfunction

	// sequence follow-up for one data word
	function automatic void track_data_seq(logic [SEQ_W-1:0] sq);
		int seq_delta;
		int gap;
		int first;
		int j;
		bit hit;
		if (!model_stats.seq_started) begin
			model_stats.highest_seq = sq;
			model_stats.seq_started = 1'b1;
			return;
		end
		seq_delta = int'(sq) - int'(model_stats.highest_seq);
		if (seq_delta > WINDOW)
			seq_delta -= SEQ_SPAN;
		else if (seq_delta < -WINDOW)
			seq_delta += SEQ_SPAN;
		if (seq_delta > 0) begin
			gap = seq_delta - 1;
			model_stats.lost_count = counter_add(model_stats.lost_count, gap);
			// only the newest numbers fit when the gap exceeds the ring
			first = (gap > TRACK_DEPTH) ? gap - TRACK_DEPTH + 1 : 1;
			for (j = first; j <= gap; j++) begin
				gap_ring[gap_ring_wr] = model_stats.highest_seq + j[SEQ_W-1:0];
				gap_ring_ok[gap_ring_wr] = 1'b1;
				gap_ring_wr = (gap_ring_wr + 1) % TRACK_DEPTH;
			end
			model_stats.highest_seq = sq;
		end else begin
			hit = 1'b0;
			for (j = 0; j < TRACK_DEPTH && !hit; j++) begin
				if (gap_ring_ok[j] && gap_ring[j] == sq) begin
					gap_ring_ok[j] = 1'b0;
					hit = 1'b1;
					if (model_stats.lost_count != 0)
						model_stats.lost_count--;
				end
			end
			if (!hit)
				model_stats.duplicate_count = counter_add(model_stats.duplicate_count, 1);
			model_stats.disorder_count = counter_add(model_stats.disorder_count, 1);
		end
	endfunction

	function automatic void predict_stats(logic [1:0] word_kind, logic [SEQ_W-1:0] word_seq,
			logic [SEQ_W-1:0] word_size);
		case (word_kind)
			KIND_DATA: begin
				model_stats.data_packets = counter_add(model_stats.data_packets, 1);
				model_stats.data_bytes = counter_add(model_stats.data_bytes,
					CNT_W'(word_size));
				track_data_seq(word_seq);
			end
			KIND_PARITY: begin
				model_stats.parity_packets = counter_add(model_stats.parity_packets, 1);
				model_stats.parity_bytes = counter_add(model_stats.parity_bytes,
					CNT_W'(word_size));
			end
			KIND_RECOVERED: begin
				model_stats.recovered_count = counter_add(model_stats.recovered_count, 1);
			end
			default: begin
				// loss, ring and sequence tracking survive a clear
				model_stats.duplicate_count = '0;
				model_stats.disorder_count  = '0;
				model_stats.recovered_count = '0;
				model_stats.data_packets    = '0;
				model_stats.data_bytes      = '0;
				model_stats.parity_packets  = '0;
				model_stats.parity_bytes    = '0;
			end
		endcase
		expected_stats.push_back(model_stats);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!sender_gaps || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [SEQ_W-1:0] random_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return SEQ_W'($urandom());
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_total++;
		if (mismatch_total <= PRINT_MAX)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] seen);
		if (seen !== want)
			report_mismatch($sformatf("%s expected 0x%h got 0x%h", name, want, seen));
	endtask

	task automatic send_word(logic [1:0] word_kind, logic [SEQ_W-1:0] word_seq,
			logic [SEQ_W-1:0] word_size);
		int gap;
		@(negedge clk);
		pkt_valid   <= 1'b1;
		kind        <= word_kind;
		seq_number  <= word_seq;
		packet_size <= word_size;
		do
			@(posedge clk);
		while (pkt_stall !== 1'b0);
		predict_stats(word_kind, word_seq, word_size);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			pkt_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		pkt_valid <= 1'b0;
		while (expected_stats.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_word();
		int pick;
		int step;
		int slot;
		int j;
		logic [SEQ_W-1:0] sq;
		logic [SEQ_W-1:0] sz;
		pick = $urandom_range(0, 99);
		sz = random_size();
		if (!model_stats.seq_started || pick < 50) begin
			step = 1;
			if ($urandom_range(0, 4) == 0)
				step = $urandom_range(2, 8);
			else if ($urandom_range(0, 29) == 0)
				step = $urandom_range(9, WINDOW);
			sq = model_stats.highest_seq + step[SEQ_W-1:0];
			// remember skipped numbers so they can arrive late
			for (j = 1; j < step; j++) begin
				late_pool.push_back(model_stats.highest_seq + j[SEQ_W-1:0]);
				if (late_pool.size() > LATE_POOL_MAX)
					void'(late_pool.pop_front());
			end
			send_word(KIND_DATA, sq, sz);
		end else if (pick < 62) begin
			if (late_pool.size() != 0 && $urandom_range(0, 3) != 0) begin
				slot = $urandom_range(0, late_pool.size() - 1);
				sq = late_pool[slot];
				late_pool.delete(slot);
			end else begin
				sq = model_stats.highest_seq - SEQ_W'($urandom_range(0, 20));
			end
			send_word(KIND_DATA, sq, sz);
		end else if (pick < 66) begin
			send_word(KIND_DATA, SEQ_W'($urandom()), sz);
		end else if (pick < 82) begin
			send_word(KIND_PARITY, SEQ_W'($urandom()), sz);
		end else if (pick < 96) begin
			send_word(KIND_RECOVERED, SEQ_W'($urandom()), sz);
		end else begin
			send_word(KIND_CLEAR, SEQ_W'($urandom()), sz);
		end
	endtask

	task automatic test_counters_before_start();
		send_word(KIND_PARITY, 16'h0000, 16'hffff);
		send_word(KIND_PARITY, 16'hffff, 16'h0000);
		send_word(KIND_RECOVERED, 16'h5a5a, 16'ha5a5);
		send_word(KIND_CLEAR, 16'hffff, 16'hffff);
	endtask

	task automatic test_sequence_wrap();
		send_word(KIND_DATA, 16'hfff0, 16'h0000);
		send_word(KIND_DATA, 16'hfff1, 16'hffff);
		send_word(KIND_DATA, 16'hfff1, 16'h0040);
		// jump across the wrap point
		send_word(KIND_DATA, 16'h0002, 16'h0100);
		send_word(KIND_DATA, 16'hfffa, 16'h0200);
		send_word(KIND_DATA, 16'hfffa, 16'h0200);
	endtask

	task automatic test_ring_overflow();
		// full window jump: more gap numbers than ring slots
		send_word(KIND_DATA, 16'h0101, 16'h0010);
		send_word(KIND_DATA, 16'h0090, 16'h0020);
		send_word(KIND_DATA, 16'h0080, 16'h0030);
	endtask

	task automatic test_window_edges();
		send_word(KIND_DATA, 16'h0002, 16'h0001);
		send_word(KIND_DATA, 16'h0001, 16'h0002);
		send_word(KIND_DATA, 16'h0200, 16'h0003);
		send_word(KIND_DATA, 16'h0100, 16'h0004);
	endtask

	task automatic test_clear_keeps_loss();
		send_word(KIND_CLEAR, 16'h0000, 16'h0000);
		send_word(KIND_DATA, 16'h0101, 16'hffff);
		send_word(KIND_RECOVERED, 16'hffff, 16'h0000);
	endtask

	task automatic test_random_stream();
		int seg;
		for (seg = 0; seg < 10; seg++) begin
			sender_gaps = (seg != 0) && ($urandom_range(0, 3) != 0);
			receiver_stalls = (seg != 0) && ($urandom_range(0, 3) != 0);
			repeat (90) send_random_word();
		end
	endtask

	task automatic test_output_backpressure();
		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		hold_request = 400;
		repeat (8) send_random_word();
		wait_for_results();
	endtask

	task automatic test_sender_pause();
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		repeat (20) send_random_word();
		wait_for_results();
		repeat (20) send_random_word();
	endtask

	// receiver: long hold on request, otherwise random stall runs
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			stat_stall <= 1'b1;
		end else if (stall_run > 0) begin
			stall_run--;
			stat_stall <= 1'b1;
		end else if (receiver_stalls && $urandom_range(0, 99) < 30) begin
			stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
			stat_stall <= 1'b1;
		end else begin
			stat_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		stat_word_t seen;
		stat_word_t want;
		if (arst_n && stat_valid && !stat_stall) begin
			seen = '{lost_count, duplicate_count, disorder_count, recovered_count, data_packets,
				data_bytes, parity_packets, parity_bytes, highest_seq, seq_started};
			if (expected_stats.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				want = expected_stats.pop_front();
				check_field("lost_count", want.lost_count, seen.lost_count);
				check_field("duplicate_count", want.duplicate_count, seen.duplicate_count);
				check_field("disorder_count", want.disorder_count, seen.disorder_count);
				check_field("recovered_count", want.recovered_count, seen.recovered_count);
				check_field("data_packets", want.data_packets, seen.data_packets);
				check_field("data_bytes", want.data_bytes, seen.data_bytes);
				check_field("parity_packets", want.parity_packets, seen.parity_packets);
				check_field("parity_bytes", want.parity_bytes, seen.parity_bytes);
				check_field("highest_seq", CNT_W'(want.highest_seq),
					CNT_W'(seen.highest_seq));
				check_field("seq_started", CNT_W'(want.seq_started),
					CNT_W'(seen.seq_started));
			end
		end
	end

	always @(posedge clk) begin
		if ((pkt_valid && !pkt_stall) || (stat_valid && !stat_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("packet_sequence_loss_tracker_tb NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		pkt_valid   = 1'b0;
		kind        = KIND_DATA;
		seq_number  = '0;
		packet_size = '0;
		stat_stall  = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		test_counters_before_start();
		test_sequence_wrap();
		test_ring_overflow();
		test_window_edges();
		test_clear_keeps_loss();
		test_random_stream();
		test_output_backpressure();
		test_sender_pause();

		wait_for_results();
		repeat (TRACK_DEPTH + 16) @(posedge clk);
		if (expected_stats.size() != 0)
			report_mismatch($sformatf("%0d result words never arrived", expected_stats.size()));
		if (mismatch_total == 0)
			$display("packet_sequence_loss_tracker_tb OK");
		else
			$display("packet_sequence_loss_tracker_tb NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
